@@ sv/gcbs_pkg.sv @@
package gcbs_pkg;

  // Field and register widths
  localparam int SIZE_W  = 11;
  localparam int GHOST_W = 4;
  localparam int COORD_W = 10;
  localparam int IDX_W   = 30;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = 2 * SIZE_W;
  localparam int CFG_A_W = 3;

  // Default parameter values
  localparam int MAX_DIM_DEF   = 1024;
  localparam int MAX_GHOST_DEF = 8;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_SIZE_X      = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SIZE_Y      = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_SIZE_Z      = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_GHOST_WIDTH = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_NEGATE_AXIS = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_FACE_ENABLE = 3'd5;

  // Boundary kinds
  localparam logic [2:0] KIND_REFLECT  = 3'd0;
  localparam logic [2:0] KIND_OUTFLOW  = 3'd1;
  localparam logic [2:0] KIND_INFLOW   = 3'd2;
  localparam logic [2:0] KIND_PERIODIC = 3'd3;
  localparam logic [2:0] KIND_SHEAR    = 3'd4;

  // Face axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;

  // Actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_COPY  = 3'd1;
  localparam logic [2:0] ACT_NEG   = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_ERR   = 3'd4;

  typedef struct packed {
    logic [2:0]         face;
    logic [2:0]         layer;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
    logic [2:0]         boundary_kind;
    logic [VAL_W-1:0]   inflow_value;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [IDX_W-1:0] src_index;
    logic [2:0]       action;
    logic [VAL_W-1:0] value_out;
  } out_word_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
    logic [GHOST_W-1:0] ghost_width;
    logic [1:0]         negate_axis;
    logic [5:0]         face_enable;
  } cfg_t;

  // Decoded cell: coordinates of destination and source, saturated x and y sizes, action, value
  typedef struct packed {
    logic [SIZE_W-1:0] dx;
    logic [SIZE_W-1:0] dy;
    logic [SIZE_W-1:0] dz;
    logic [SIZE_W-1:0] sxc;
    logic [SIZE_W-1:0] syc;
    logic [SIZE_W-1:0] szc;
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [2:0]        action;
    logic [VAL_W-1:0]  value;
  } dec_t;

  // Load enables of the index stages
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stg_en_t;

endpackage

@@ sv/gcbs_decode.sv @@
module gcbs_decode #(
  parameter int MAX_DIM   = gcbs_pkg::MAX_DIM_DEF,
  parameter int MAX_GHOST = gcbs_pkg::MAX_GHOST_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  gcbs_pkg::in_word_t in_word,
  input  gcbs_pkg::cfg_t    cfg,
  output gcbs_pkg::dec_t    dec_r
);

  localparam int SW = gcbs_pkg::SIZE_W;
  localparam int CW = SW + 2;

  gcbs_pkg::dec_t dec_nxt;

  logic [SW-1:0] nx, ny, nz, n, du, dv, g, two_g, lay, face_pos, src_pos;
  logic [gcbs_pkg::GHOST_W-1:0] gs;
  logic [1:0]    axis;
  logic          hi, face_ok, cell_ok, copy;
  logic [7:0]    fe8;
  logic [2:0]    act;

  // Saturate sizes and ghost width, check the cell, build coordinates
  always_comb begin
    nx = ({2'b0, cfg.size_x} > CW'(MAX_DIM)) ? SW'(MAX_DIM) : cfg.size_x;
    ny = ({2'b0, cfg.size_y} > CW'(MAX_DIM)) ? SW'(MAX_DIM) : cfg.size_y;
    nz = ({2'b0, cfg.size_z} > CW'(MAX_DIM)) ? SW'(MAX_DIM) : cfg.size_z;
    gs = ({1'b0, cfg.ghost_width} > 5'(MAX_GHOST)) ? gcbs_pkg::GHOST_W'(MAX_GHOST)
                                                   : cfg.ghost_width;
    g     = SW'(gs);
    two_g = SW'({gs, 1'b0});
    lay   = SW'(in_word.layer);
    axis  = in_word.face[2:1];
    hi    = in_word.face[0];
    fe8   = {2'b00, cfg.face_enable};
    face_ok = (in_word.face <= 3'd5) && fe8[in_word.face];

    unique case (axis)
      gcbs_pkg::AXIS_X: begin
        n = nx; du = ny; dv = nz;
      end
      gcbs_pkg::AXIS_Y: begin
        n = ny; du = nx; dv = nz;
      end
      default: begin
        n = nz; du = nx; dv = ny;
      end
    endcase

    cell_ok = face_ok && (lay < g) && (n > two_g)
              && (SW'(in_word.coord_u) < du) && (SW'(in_word.coord_v) < dv);

    face_pos = hi ? (n - g + lay) : lay;

    // Source coordinate on the face axis and the action
    src_pos = '0;
    unique case (in_word.boundary_kind)
      gcbs_pkg::KIND_REFLECT: begin
        src_pos = hi ? (n - g - SW'(1) - lay) : (two_g - SW'(1) - lay);
        act = (cfg.negate_axis == (axis + 2'd1)) ? gcbs_pkg::ACT_NEG : gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_OUTFLOW: begin
        src_pos = hi ? (n - g - SW'(1)) : g;
        act = gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_INFLOW:   act = gcbs_pkg::ACT_WRITE;
      gcbs_pkg::KIND_PERIODIC: begin
        src_pos = hi ? (g + lay) : (lay + n - two_g);
        act = gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_SHEAR:    act = gcbs_pkg::ACT_NONE;
      default:                 act = gcbs_pkg::ACT_ERR;
    endcase

    copy = cell_ok && ((act == gcbs_pkg::ACT_COPY) || (act == gcbs_pkg::ACT_NEG));

    dec_nxt.nx = nx;
    dec_nxt.ny = ny;

    // Place the coordinates by face axis; zero the destination for a dropped cell and the source for a non-copy
    unique case (axis)
      gcbs_pkg::AXIS_X: begin
        dec_nxt.dx  = face_pos;
        dec_nxt.dy  = SW'(in_word.coord_u);
        dec_nxt.dz  = SW'(in_word.coord_v);
        dec_nxt.sxc = src_pos;
        dec_nxt.syc = SW'(in_word.coord_u);
        dec_nxt.szc = SW'(in_word.coord_v);
      end
      gcbs_pkg::AXIS_Y: begin
        dec_nxt.dx  = SW'(in_word.coord_u);
        dec_nxt.dy  = face_pos;
        dec_nxt.dz  = SW'(in_word.coord_v);
        dec_nxt.sxc = SW'(in_word.coord_u);
        dec_nxt.syc = src_pos;
        dec_nxt.szc = SW'(in_word.coord_v);
      end
      default: begin
        dec_nxt.dx  = SW'(in_word.coord_u);
        dec_nxt.dy  = SW'(in_word.coord_v);
        dec_nxt.dz  = face_pos;
        dec_nxt.sxc = SW'(in_word.coord_u);
        dec_nxt.syc = SW'(in_word.coord_v);
        dec_nxt.szc = src_pos;
      end
    endcase

    if (!cell_ok) begin
      dec_nxt.dx = '0;
      dec_nxt.dy = '0;
      dec_nxt.dz = '0;
    end
    if (!copy) begin
      dec_nxt.sxc = '0;
      dec_nxt.syc = '0;
      dec_nxt.szc = '0;
    end
    dec_nxt.action = cell_ok ? act : gcbs_pkg::ACT_NONE;
    dec_nxt.value  = (cell_ok && (act == gcbs_pkg::ACT_WRITE)) ? in_word.inflow_value : '0;
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

@@ sv/gcbs_linear.sv @@
module gcbs_linear (
  input  logic                          clk,
  input  gcbs_pkg::stg_en_t             en,
  input  logic [gcbs_pkg::SIZE_W-1:0]   x,
  input  logic [gcbs_pkg::SIZE_W-1:0]   y,
  input  logic [gcbs_pkg::SIZE_W-1:0]   z,
  input  logic [gcbs_pkg::SIZE_W-1:0]   nx,
  input  logic [gcbs_pkg::SIZE_W-1:0]   ny,
  output logic [gcbs_pkg::IDX_W-1:0]    idx_r
);

  localparam int SW = gcbs_pkg::SIZE_W;
  localparam int PW = gcbs_pkg::PROD_W;
  localparam int IW = gcbs_pkg::IDX_W;

  logic [SW-1:0]   x2_r, z2_r;
  logic [PW-1:0]   ysx_r, plane_r;
  logic [PW:0]     base_r;
  logic [IW-1:0]   zp_r;
  logic [PW+SW-1:0] zprod;

  assign zprod = PW'(plane_r) * (PW+SW)'(z2_r);

  // Stage 2: row offset and plane size
  always_ff @(posedge clk) begin
    if (en.s2) begin
      ysx_r   <= PW'(y) * PW'(nx);
      plane_r <= PW'(nx) * PW'(ny);
      x2_r    <= x;
      z2_r    <= z;
    end
  end

  // Stage 3: plane offset, in-plane sum
  always_ff @(posedge clk) begin
    if (en.s3) begin
      zp_r   <= zprod[IW-1:0];
      base_r <= (PW+1)'(ysx_r) + (PW+1)'(x2_r);
    end
  end

  // Stage 4: final index, wrapped to the index width
  always_ff @(posedge clk) begin
    if (en.s4) begin
      idx_r <= zp_r + IW'(base_r);
    end
  end

endmodule

@@ sv/ghost_cell_boundary_source_unit.sv @@
// Ghost cell boundary source: destination index, source index and action per cell.
// Stages: decode register, then three index stages splitting the index multipliers.
// Throughput: one word per cycle while the output is not stalled.
// Bubbles in the pipeline are squeezed out while the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default registers.
module ghost_cell_boundary_source_unit #(
  parameter int MAX_DIM   = gcbs_pkg::MAX_DIM_DEF,
  parameter int MAX_GHOST = gcbs_pkg::MAX_GHOST_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  gcbs_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output gcbs_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [gcbs_pkg::CFG_A_W-1:0]    cfg_addr,
  input  logic [gcbs_pkg::SIZE_W-1:0]     cfg_wdata
);

  gcbs_pkg::cfg_t    cfg_r;
  gcbs_pkg::dec_t    dec_r;
  gcbs_pkg::stg_en_t en;

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;
  logic [2:0]                   act2_r, act3_r, act4_r;
  logic [gcbs_pkg::VAL_W-1:0]   val2_r, val3_r, val4_r;
  logic [gcbs_pkg::IDX_W-1:0]   dest_idx, src_idx;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x      <= gcbs_pkg::SIZE_W'(16);
      cfg_r.size_y      <= gcbs_pkg::SIZE_W'(16);
      cfg_r.size_z      <= gcbs_pkg::SIZE_W'(16);
      cfg_r.ghost_width <= gcbs_pkg::GHOST_W'(3);
      cfg_r.negate_axis <= 2'd0;
      cfg_r.face_enable <= 6'h3f;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        gcbs_pkg::REG_SIZE_X:      cfg_r.size_x      <= cfg_wdata;
        gcbs_pkg::REG_SIZE_Y:      cfg_r.size_y      <= cfg_wdata;
        gcbs_pkg::REG_SIZE_Z:      cfg_r.size_z      <= cfg_wdata;
        gcbs_pkg::REG_GHOST_WIDTH: cfg_r.ghost_width <= cfg_wdata[gcbs_pkg::GHOST_W-1:0];
        gcbs_pkg::REG_NEGATE_AXIS: cfg_r.negate_axis <= cfg_wdata[1:0];
        gcbs_pkg::REG_FACE_ENABLE: cfg_r.face_enable <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or the next one moves
  assign rdy4     = !v4_r || !out_stall;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign en.s2    = rdy2;
  assign en.s3    = rdy3;
  assign en.s4    = rdy4;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  gcbs_decode #(
    .MAX_DIM   (MAX_DIM),
    .MAX_GHOST (MAX_GHOST)
  ) u_decode (
    .clk     (clk),
    .en      (rdy1),
    .in_word (in_data),
    .cfg     (cfg_r),
    .dec_r   (dec_r)
  );

  gcbs_linear u_dest (
    .clk   (clk),
    .en    (en),
    .x     (dec_r.dx),
    .y     (dec_r.dy),
    .z     (dec_r.dz),
    .nx    (dec_r.nx),
    .ny    (dec_r.ny),
    .idx_r (dest_idx)
  );

  gcbs_linear u_src (
    .clk   (clk),
    .en    (en),
    .x     (dec_r.sxc),
    .y     (dec_r.syc),
    .z     (dec_r.szc),
    .nx    (dec_r.nx),
    .ny    (dec_r.ny),
    .idx_r (src_idx)
  );

  // Carry action and value alongside the index stages
  always_ff @(posedge clk) begin
    if (rdy2) begin
      act2_r <= dec_r.action;
      val2_r <= dec_r.value;
    end
    if (rdy3) begin
      act3_r <= act2_r;
      val3_r <= val2_r;
    end
    if (rdy4) begin
      act4_r <= act3_r;
      val4_r <= val3_r;
    end
  end

  assign out_valid           = v4_r;
  assign out_data.dest_index = dest_idx;
  assign out_data.src_index  = src_idx;
  assign out_data.action     = act4_r;
  assign out_data.value_out  = val4_r;

endmodule

@@ bench/tb_ghost_cell_boundary_source_unit.sv @@
module tb_ghost_cell_boundary_source_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Face codes, including the two that name no face
  localparam logic [2:0] FACE_X_LO  = 3'd0;
  localparam logic [2:0] FACE_X_HI  = 3'd1;
  localparam logic [2:0] FACE_Y_LO  = 3'd2;
  localparam logic [2:0] FACE_Y_HI  = 3'd3;
  localparam logic [2:0] FACE_Z_LO  = 3'd4;
  localparam logic [2:0] FACE_Z_HI  = 3'd5;
  localparam logic [2:0] FACE_BAD_A = 3'd6;
  localparam logic [2:0] FACE_BAD_B = 3'd7;

  // Boundary kinds with no defined meaning
  localparam logic [2:0] KIND_UNDEF_A = 3'd5;
  localparam logic [2:0] KIND_UNDEF_B = 3'd6;
  localparam logic [2:0] KIND_UNDEF_C = 3'd7;

  // Negated velocity axis settings
  localparam logic [1:0] NEG_OFF = 2'd0;
  localparam logic [1:0] NEG_X   = 2'd1;
  localparam logic [1:0] NEG_Y   = 2'd2;
  localparam logic [1:0] NEG_Z   = 2'd3;

  localparam logic [5:0] ALL_FACES   = 6'h3F;
  localparam int         MAX_GAP     = 13;
  localparam int         SETTLE      = 8;
  localparam int         QUIET_LIMIT = 3000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  gcbs_pkg::in_word_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  gcbs_pkg::out_word_t           out_data;
  logic                          cfg_we;
  logic [gcbs_pkg::CFG_A_W-1:0]  cfg_addr;
  logic [gcbs_pkg::SIZE_W-1:0]   cfg_wdata;

  // Local copy of the register file
  logic [gcbs_pkg::SIZE_W-1:0]  cur_size [3];
  logic [gcbs_pkg::GHOST_W-1:0] cur_ghost;
  logic [1:0]                   cur_negate;
  logic [5:0]                   cur_faces;

  gcbs_pkg::out_word_t pending_fills[$];
  int        mismatch_cnt;
  int        quiet_cycles;
  int        hold_cycles;
  bit        tx_gaps;
  bit        rx_stalls;

  ghost_cell_boundary_source_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Saturated size of one axis
  function automatic int dim_of(int ax);
    return (cur_size[ax] > gcbs_pkg::MAX_DIM_DEF) ? gcbs_pkg::MAX_DIM_DEF
                                                  : int'(cur_size[ax]);
  endfunction

  function automatic int ghost_of();
    return (cur_ghost > gcbs_pkg::MAX_GHOST_DEF) ? gcbs_pkg::MAX_GHOST_DEF : int'(cur_ghost);
  endfunction

  function automatic longint unsigned flat_index(longint unsigned x, longint unsigned y,
                                                 longint unsigned z, longint unsigned nx,
                                                 longint unsigned ny);
    return (x + y * nx + z * nx * ny) & 64'h3FFF_FFFF;
  endfunction

  // Destination, source and action of one ghost cell under the current registers
  function automatic gcbs_pkg::out_word_t fill_cell(gcbs_pkg::in_word_t w);
    gcbs_pkg::out_word_t r;
    longint unsigned d [3];
    longint unsigned p [3];
    longint unsigned s [3];
    longint unsigned g;
    longint unsigned n;
    int              ax;
    int              a1;
    int              a2;
    logic            hi;
    logic [2:0]      act;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = 64'(dim_of(i));
    end
    g = 64'(ghost_of());
    if (w.face > FACE_Z_HI || !cur_faces[w.face]) return r;
    ax = int'(w.face >> 1);
    hi = w.face[0];
    n  = d[ax];
    if (w.layer >= g || n <= 2 * g) return r;
    a1 = (ax == 0) ? 1 : 0;
    a2 = (ax == 2) ? 1 : 2;
    if (w.coord_u >= d[a1] || w.coord_v >= d[a2]) return r;
    p[a1] = 64'(w.coord_u);
    p[a2] = 64'(w.coord_v);
    p[ax] = hi ? n - g + w.layer : 64'(w.layer);
    r.dest_index = gcbs_pkg::IDX_W'(flat_index(p[0], p[1], p[2], d[0], d[1]));
    for (int i = 0; i < 3; i++) begin
      s[i] = p[i];
    end
    case (w.boundary_kind)
      gcbs_pkg::KIND_REFLECT: begin
        s[ax] = hi ? n - g - 1 - w.layer : 2 * g - 1 - w.layer;
        act   = (cur_negate == ax + 1) ? gcbs_pkg::ACT_NEG : gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_OUTFLOW: begin
        s[ax] = hi ? n - g - 1 : g;
        act   = gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_INFLOW: act = gcbs_pkg::ACT_WRITE;
      gcbs_pkg::KIND_PERIODIC: begin
        s[ax] = hi ? g + w.layer : w.layer + (n - 2 * g);
        act   = gcbs_pkg::ACT_COPY;
      end
      gcbs_pkg::KIND_SHEAR: act = gcbs_pkg::ACT_NONE;
      default: act = gcbs_pkg::ACT_ERR;
    endcase
    if (act == gcbs_pkg::ACT_COPY || act == gcbs_pkg::ACT_NEG) begin
      r.src_index = gcbs_pkg::IDX_W'(flat_index(s[0], s[1], s[2], d[0], d[1]));
    end
    if (act == gcbs_pkg::ACT_WRITE) begin
      r.value_out = w.inflow_value;
    end
    r.action = act;
    return r;
  endfunction

  function automatic gcbs_pkg::in_word_t make_cell(logic [2:0] face, int layer, int u, int v,
                                                   logic [2:0] kind,
                                                   logic [gcbs_pkg::VAL_W-1:0] val);
    gcbs_pkg::in_word_t w;
    w.face          = face;
    w.layer         = 3'(layer);
    w.coord_u       = gcbs_pkg::COORD_W'(u);
    w.coord_v       = gcbs_pkg::COORD_W'(v);
    w.boundary_kind = kind;
    w.inflow_value  = val;
    return w;
  endfunction

  function automatic int pick_coord(int dim);
    if (dim == 0) return $urandom_range(0, gcbs_pkg::MAX_DIM_DEF - 1);
    if ($urandom_range(0, 3) == 0) return dim - 1;
    return $urandom_range(0, dim - 1);
  endfunction

  // Mostly cells that land on an enabled face inside the grid, the rest raw noise
  function automatic gcbs_pkg::in_word_t random_cell();
    gcbs_pkg::in_word_t w;
    int       g;
    int       ax;
    w.face          = 3'($urandom_range(0, 7));
    w.layer         = 3'($urandom_range(0, 7));
    w.coord_u       = gcbs_pkg::COORD_W'($urandom_range(0, gcbs_pkg::MAX_DIM_DEF - 1));
    w.coord_v       = gcbs_pkg::COORD_W'($urandom_range(0, gcbs_pkg::MAX_DIM_DEF - 1));
    w.boundary_kind = 3'($urandom_range(0, 7));
    w.inflow_value  = $urandom;
    if ($urandom_range(0, 99) < 85) begin
      if (cur_faces != 0) begin
        do w.face = 3'($urandom_range(FACE_X_LO, FACE_Z_HI)); while (!cur_faces[w.face]);
      end else begin
        w.face = 3'($urandom_range(FACE_X_LO, FACE_Z_HI));
      end
      g = ghost_of();
      if (g > 0) w.layer = 3'($urandom_range(0, g - 1));
      ax = int'(w.face >> 1);
      w.coord_u = gcbs_pkg::COORD_W'(pick_coord(dim_of((ax == 0) ? 1 : 0)));
      w.coord_v = gcbs_pkg::COORD_W'(pick_coord(dim_of((ax == 2) ? 1 : 2)));
      w.boundary_kind = ($urandom_range(0, 9) != 0) ?
                        3'($urandom_range(gcbs_pkg::KIND_REFLECT, gcbs_pkg::KIND_SHEAR)) :
                        3'($urandom_range(KIND_UNDEF_A, KIND_UNDEF_C));
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_cnt++;
    $display("%0t: fill %s got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Offer one word, after a random gap when tx_gaps is set; returns at the edge that takes it
  task automatic send_word(gcbs_pkg::in_word_t w);
    int gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_cells(int count);
    repeat (count) send_word(random_cell());
  endtask

  // Drop valid and wait until every expected word is out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fills.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [gcbs_pkg::CFG_A_W-1:0] idx,
                           logic [gcbs_pkg::SIZE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      gcbs_pkg::REG_SIZE_X:      cur_size[0] = val;
      gcbs_pkg::REG_SIZE_Y:      cur_size[1] = val;
      gcbs_pkg::REG_SIZE_Z:      cur_size[2] = val;
      gcbs_pkg::REG_GHOST_WIDTH: cur_ghost   = val[gcbs_pkg::GHOST_W-1:0];
      gcbs_pkg::REG_NEGATE_AXIS: cur_negate  = val[1:0];
      gcbs_pkg::REG_FACE_ENABLE: cur_faces   = val[5:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(int sx, int sy, int sz, int g, logic [1:0] neg, logic [5:0] fe);
    drain();
    write_reg(gcbs_pkg::REG_SIZE_X, gcbs_pkg::SIZE_W'(sx));
    write_reg(gcbs_pkg::REG_SIZE_Y, gcbs_pkg::SIZE_W'(sy));
    write_reg(gcbs_pkg::REG_SIZE_Z, gcbs_pkg::SIZE_W'(sz));
    write_reg(gcbs_pkg::REG_GHOST_WIDTH, gcbs_pkg::SIZE_W'(g));
    write_reg(gcbs_pkg::REG_NEGATE_AXIS, gcbs_pkg::SIZE_W'(neg));
    write_reg(gcbs_pkg::REG_FACE_ENABLE, gcbs_pkg::SIZE_W'(fe));
    cfg_we <= 1'b0;
  endtask

  // Reset registers: each face, each kind, and the invalid-cell cases
  task automatic test_directed_cells();
    send_word(make_cell(FACE_X_LO, 0, 5, 7, gcbs_pkg::KIND_REFLECT, 32'h1234_5678));
    send_word(make_cell(FACE_X_HI, 2, 15, 15, gcbs_pkg::KIND_REFLECT, 32'h0));
    send_word(make_cell(FACE_Y_LO, 1, 0, 0, gcbs_pkg::KIND_OUTFLOW, 32'h0));
    send_word(make_cell(FACE_Y_HI, 0, 3, 9, gcbs_pkg::KIND_OUTFLOW, 32'h0));
    send_word(make_cell(FACE_Z_LO, 2, 8, 8, gcbs_pkg::KIND_INFLOW, 32'hFFFF_FFFF));
    send_word(make_cell(FACE_Z_HI, 1, 1, 2, gcbs_pkg::KIND_INFLOW, 32'h0));
    send_word(make_cell(FACE_X_LO, 2, 4, 4, gcbs_pkg::KIND_PERIODIC, 32'h0));
    send_word(make_cell(FACE_X_HI, 0, 4, 4, gcbs_pkg::KIND_PERIODIC, 32'h0));
    send_word(make_cell(FACE_Z_HI, 2, 4, 4, gcbs_pkg::KIND_PERIODIC, 32'h0));
    send_word(make_cell(FACE_Y_LO, 0, 6, 6, gcbs_pkg::KIND_SHEAR, 32'hDEAD_BEEF));
    send_word(make_cell(FACE_Y_HI, 1, 6, 6, KIND_UNDEF_A, 32'hDEAD_BEEF));
    send_word(make_cell(FACE_Z_LO, 0, 6, 6, KIND_UNDEF_B, 32'h0));
    send_word(make_cell(FACE_Z_HI, 0, 6, 6, KIND_UNDEF_C, 32'h0));
    send_word(make_cell(FACE_BAD_A, 0, 2, 2, gcbs_pkg::KIND_REFLECT, 32'h0));
    send_word(make_cell(FACE_BAD_B, 0, 2, 2, gcbs_pkg::KIND_INFLOW, 32'hFFFF_FFFF));
    // layer equal to the ghost width, and the deepest layer
    send_word(make_cell(FACE_X_LO, 3, 2, 2, gcbs_pkg::KIND_OUTFLOW, 32'h0));
    send_word(make_cell(FACE_Y_HI, 7, 2, 2, gcbs_pkg::KIND_INFLOW, 32'hFFFF_FFFF));
    // in-plane coordinates one past the grid and at full scale
    send_word(make_cell(FACE_X_HI, 1, 16, 3, gcbs_pkg::KIND_REFLECT, 32'h0));
    send_word(make_cell(FACE_Z_LO, 1, 3, 16, gcbs_pkg::KIND_REFLECT, 32'h0));
    send_word(make_cell(FACE_Y_LO, 0, 1023, 1023, gcbs_pkg::KIND_INFLOW, 32'hFFFF_FFFF));
  endtask

  task automatic test_default_grid();
    run_cells(50);
  endtask

  // Full-size grid, widest ghost zone, x reflection negated
  task automatic test_large_grid();
    apply_setup(gcbs_pkg::MAX_DIM_DEF, gcbs_pkg::MAX_DIM_DEF, gcbs_pkg::MAX_DIM_DEF,
                gcbs_pkg::MAX_GHOST_DEF, NEG_X, ALL_FACES);
    send_word(make_cell(FACE_X_LO, 7, 1023, 1023, gcbs_pkg::KIND_REFLECT, 32'h0));
    send_word(make_cell(FACE_Z_HI, 7, 1023, 1023, gcbs_pkg::KIND_PERIODIC, 32'h0));
    run_cells(60);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    run_cells(60);
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // Sizes and ghost width above their ceilings
  task automatic test_saturation();
    apply_setup(2047, 1500, 1025, 15, NEG_Y, 6'b101010);
    run_cells(80);
    apply_setup(1024, 2047, 17, 9, NEG_Z, 6'b010101);
    run_cells(40);
  endtask

  // Empty axes, no active cells, no ghost layers, all faces off
  task automatic test_degenerate();
    apply_setup(0, 5, 7, 2, NEG_Z, ALL_FACES);
    run_cells(40);
    apply_setup(6, 7, 8, 3, NEG_Y, ALL_FACES);
    run_cells(40);
    apply_setup(3, 4, 9, 0, NEG_X, ALL_FACES);
    run_cells(30);
    apply_setup(1, 1, 1, 0, NEG_OFF, 6'h00);
    run_cells(20);
  endtask

  // Hold the output long enough to fill the pipeline, then let it drain
  task automatic test_backpressure();
    apply_setup(20, 12, 9, 2, NEG_X, ALL_FACES);
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    hold_cycles = 150;
    run_cells(60);
    drain();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    run_cells(30);
  endtask

  task automatic test_random_setups();
    repeat (8) begin
      apply_setup(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 24),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 24),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 24),
                  $urandom_range(0, 15), 2'($urandom_range(NEG_OFF, NEG_Z)),
                  6'($urandom));
      run_cells(40);
    end
  endtask

  // Receiver: random stall before each word, plus a long hold when asked
  initial begin : receiver
    int n;
    out_stall = 1'b1;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      n = rx_stalls ? $urandom_range(0, MAX_GAP) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Predict on accepted input words, compare accepted output words, watch for a hang
  always @(posedge clk) begin : scoreboard
    gcbs_pkg::out_word_t want;
    logic      took_in;
    logic      took_out;
    if (rst_n) begin
      took_in  = in_valid && !in_stall;
      took_out = out_valid && !out_stall;
      if (took_in) pending_fills.push_back(fill_cell(in_data));
      if (took_out) begin
        if (pending_fills.size() == 0) begin
          report_mismatch("unexpected word, dest", out_data.dest_index, 0);
        end else begin
          want = pending_fills.pop_front();
          if (out_data.dest_index !== want.dest_index)
            report_mismatch("dest_index", out_data.dest_index, want.dest_index);
          if (out_data.src_index !== want.src_index)
            report_mismatch("src_index", out_data.src_index, want.src_index);
          if (out_data.action !== want.action)
            report_mismatch("action", out_data.action, want.action);
          if (out_data.value_out !== want.value_out)
            report_mismatch("value_out", out_data.value_out, want.value_out);
        end
      end
      quiet_cycles = (took_in || took_out || cfg_we) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_addr     = '0;
    cfg_wdata    = '0;
    cur_size[0]  = gcbs_pkg::SIZE_W'(16);
    cur_size[1]  = gcbs_pkg::SIZE_W'(16);
    cur_size[2]  = gcbs_pkg::SIZE_W'(16);
    cur_ghost    = gcbs_pkg::GHOST_W'(3);
    cur_negate   = NEG_OFF;
    cur_faces    = ALL_FACES;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    hold_cycles  = 0;
    tx_gaps      = 1'b1;
    rx_stalls    = 1'b1;
    rst_n        = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cells();
    test_default_grid();
    test_large_grid();
    test_saturation();
    test_degenerate();
    test_backpressure();
    test_random_setups();
    drain();

    if (mismatch_cnt == 0 && pending_fills.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/gcbs_pkg.sv
sv/gcbs_decode.sv
sv/gcbs_linear.sv
sv/ghost_cell_boundary_source_unit.sv
bench/tb_ghost_cell_boundary_source_unit.sv
